/* rtl/rpp_pkg.sv */
// shared widths, register codes and types for the radar point projector
// no dependencies; used by rpp_div and radar_point_to_pixel_projection
package rpp_pkg;

  localparam int COEF_W  = 16;   // q4.12 matrix coefficient
  localparam int IN_W    = 16;   // q8.8 radar coordinate
  localparam int PROD1_W = 2 * COEF_W;
  localparam int WLD_W   = 34;   // world coordinate, 20 fraction bits
  localparam int PROD2_W = COEF_W + WLD_W;
  localparam int CAM_W   = 52;   // camera coordinate, 32 fraction bits
  localparam int MAG_W   = 51;   // magnitude of a camera coordinate
  localparam int LO_W    = 26;   // low slice of the magnitude multiply
  localparam int HI_W    = MAG_W - LO_W;
  localparam int F_W     = 32;   // q16.16 focal length
  localparam int FULL_W  = MAG_W + F_W;
  localparam int NUM_W   = FULL_W - 12;  // numerator with depth scale removed
  localparam int DEN_W   = 51;   // positive depth
  localparam int Q_W     = 42;   // quotient bits resolved by the divider
  localparam int CP_W    = 20;   // principal point in q.4
  localparam int PIX_W   = 21;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [Q_W-1:0] QUOT_CAP = Q_W'(64'h100_0000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RW_ROW0 = 3'd0,
    REG_RW_ROW1 = 3'd1,
    REG_RW_ROW2 = 3'd2,
    REG_WC_ROW0 = 3'd3,
    REG_WC_ROW1 = 3'd4,
    REG_WC_ROW2 = 3'd5,
    REG_FOCAL   = 3'd6,
    REG_PRINC   = 3'd7
  } cfg_reg_e;

  // per-lane sideband that rides along the divider
  typedef struct packed {
    logic neg;
    logic ovf;
  } div_tag_t;

  // column k of a packed matrix row
  function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] row,
                                                    input int k);
    coef = row[COEF_W*k +: COEF_W];
  endfunction

endpackage

/* rtl/rpp_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on rpp_pkg
module rpp_div (
  input  logic                     clk,
  input  logic                     ce,
  input  logic [rpp_pkg::NUM_W-1:0] num,
  input  logic [rpp_pkg::DEN_W-1:0] den,
  input  logic                     neg_in,
  output logic [rpp_pkg::Q_W-1:0]   quot,
  output rpp_pkg::div_tag_t         tag_out
);
  import rpp_pkg::*;

  logic [DEN_W-1:0] rem   [0:Q_W];
  logic [Q_W-1:0]   low   [0:Q_W];
  logic [Q_W-1:0]   q     [0:Q_W];
  logic [DEN_W-1:0] den_s [0:Q_W];
  div_tag_t         tag   [0:Q_W];

  logic [DEN_W-1:0] top_part;
  logic             ovf;

  // quotient needs more than Q_W bits: flag it and start from a clean remainder
  assign top_part = DEN_W'(num[NUM_W-1:Q_W]);
  assign ovf      = top_part >= den;
  assign rem[0]   = ovf ? '0 : top_part;
  assign low[0]   = num[Q_W-1:0];
  assign q[0]     = '0;
  assign den_s[0] = den;
  assign tag[0]   = '{neg: neg_in, ovf: ovf};

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] diff;
    assign trial = {1'b0, rem[k], low[k][Q_W-1]};
    assign diff  = trial - {2'b00, den_s[k]};
    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k+1]   <= diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
        q[k+1]     <= {q[k][Q_W-2:0], ~diff[DEN_W+1]};
        low[k+1]   <= {low[k][Q_W-2:0], 1'b0};
        den_s[k+1] <= den_s[k];
        tag[k+1]   <= tag[k];
      end
    end
  end

  assign quot    = q[Q_W];
  assign tag_out = tag[Q_W];

endmodule

/* rtl/radar_point_to_pixel_projection.sv */
// radar target to pixel projector: two rigid transforms, pinhole intrinsics
// depends on rpp_pkg and rpp_div
//
//  channel   dir  payload                                   handshake
//  s_axis    in   tdata: radar_x, radar_y; tlast            tvalid/tready
//  m_axis    out  tdata: pixel_u, pixel_v; tuser; tlast     tvalid/tready
//  cfg       in   cfg_index, cfg_data                       cfg_we
//
// one item per cycle while m_axis is not stalled; the 42-stage restoring
// divider resolves one quotient bit per stage
// stages: world mult-add, camera products, camera sum, magnitude,
// split focal multiply, numerator join, divider, cap, offset and saturate
// rst clears the matrices, intrinsics and all valid bits
// a stall at m_axis freezes every stage at once; s_axis_tready follows it
module radar_point_to_pixel_projection (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // radar_x, radar_y
  input  logic                             s_axis_tlast,  // last_in_frame
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata,  // pixel_u, pixel_v, zero pad
  output logic [1:0]                       m_axis_tuser,  // behind_camera, clipped
  output logic                             m_axis_tlast,  // last_out
  input  logic                             cfg_we,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpp_pkg::CFG_W-1:0]        cfg_data
);
  import rpp_pkg::*;

  typedef struct packed {
    logic valid;
    logic last;
    logic behind;
  } ctl_t;

  localparam int NCTL = 6 + Q_W;
  localparam int BEHIND_STAGE = 4;

  // configuration registers
  logic [CFG_W-1:0] rw [0:2];
  logic [CFG_W-1:0] wc [0:2];
  logic [CFG_W-1:0] focal;
  logic [CFG_W-1:0] princ;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 3; j++) begin
        rw[j] <= '0;
        wc[j] <= '0;
      end
      focal <= '0;
      princ <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_RW_ROW0: rw[0] <= cfg_data;
        REG_RW_ROW1: rw[1] <= cfg_data;
        REG_RW_ROW2: rw[2] <= cfg_data;
        REG_WC_ROW0: wc[0] <= cfg_data;
        REG_WC_ROW1: wc[1] <= cfg_data;
        REG_WC_ROW2: wc[2] <= cfg_data;
        REG_FOCAL:   focal <= cfg_data;
        REG_PRINC:   princ <= cfg_data;
        default: ;
      endcase
    end
  end

  logic ce;
  logic out_valid;
  assign ce            = !out_valid || m_axis_tready;
  assign s_axis_tready = ce;

  // control line, one entry per stage
  ctl_t ctl [1:NCTL];

  // stage 1: radar to world, 20 fraction bits
  logic signed [IN_W-1:0]    in_x, in_y;
  logic signed [PROD1_W-1:0] px [0:2];
  logic signed [PROD1_W-1:0] py [0:2];
  logic signed [WLD_W-1:0]   w_next [0:2];
  logic signed [WLD_W-1:0]   w1 [0:2];

  assign in_x = s_axis_tdata[15:0];
  assign in_y = s_axis_tdata[31:16];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      px[j]     = coef(rw[j], 0) * in_x;
      py[j]     = coef(rw[j], 1) * in_y;
      w_next[j] = WLD_W'(px[j]) + WLD_W'(py[j]) + (WLD_W'(coef(rw[j], 3)) <<< 8);
    end
  end

  // stage 2: camera row products
  logic signed [PROD2_W-1:0] cp2 [0:2][0:2];

  // stage 3: camera sums, 32 fraction bits
  logic signed [CAM_W-1:0] cam_next [0:2];
  logic signed [CAM_W-1:0] cam3 [0:2];
  logic                    behind3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_next[i] = CAM_W'(cp2[i][0]) + CAM_W'(cp2[i][1]) + CAM_W'(cp2[i][2])
                  + (CAM_W'(coef(wc[i], 3)) <<< 20);
    end
  end
  assign behind3 = cam3[2] <= 0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NCTL; k++) ctl[k] <= '0;
    end else if (ce) begin
      ctl[1] <= '{valid: s_axis_tvalid, last: s_axis_tlast, behind: 1'b0};
      for (int k = 2; k <= NCTL; k++) begin
        // depth sign joins the control line beside the magnitude stage
        if (k == BEHIND_STAGE) begin
          ctl[k] <= '{valid: ctl[k-1].valid, last: ctl[k-1].last, behind: behind3};
        end else begin
          ctl[k] <= ctl[k-1];
        end
      end
    end
  end

  // stage 4: magnitudes and depth
  logic [MAG_W-1:0] mag4 [0:1];
  logic             neg4 [0:1];
  logic [DEN_W-1:0] den4;

  // stage 5: split multiply by focal length
  logic [LO_W+F_W-1:0] plo5 [0:1];
  logic [HI_W+F_W-1:0] phi5 [0:1];
  logic                neg5 [0:1];
  logic [DEN_W-1:0]    den5;

  // stage 6: joined numerator, depth scale folded in
  logic [FULL_W-1:0]   full_next [0:1];
  logic [NUM_W-1:0]    num6 [0:1];
  logic                neg6 [0:1];
  logic [DEN_W-1:0]    den6;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      full_next[l] = FULL_W'(plo5[l]) + (FULL_W'(phi5[l]) << LO_W);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 3; j++) w1[j] <= w_next[j];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) cp2[i][j] <= coef(wc[i], j) * w1[j];
        cam3[i] <= cam_next[i];
      end
      for (int l = 0; l < 2; l++) begin
        neg4[l] <= cam3[l] < 0;
        mag4[l] <= cam3[l] < 0 ? MAG_W'(-cam3[l]) : MAG_W'(cam3[l]);
        plo5[l] <= mag4[l][LO_W-1:0] * focal[F_W*l +: F_W];
        phi5[l] <= mag4[l][MAG_W-1:LO_W] * focal[F_W*l +: F_W];
        neg5[l] <= neg4[l];
        num6[l] <= full_next[l][FULL_W-1:12];
        neg6[l] <= neg5[l];
      end
      den4 <= cam3[2][DEN_W-1:0];
      den5 <= den4;
      den6 <= den5;
    end
  end

  // dividers, one per pixel axis
  logic [Q_W-1:0] quot [0:1];
  div_tag_t       dtag [0:1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    rpp_div u_div (
      .clk     (clk),
      .ce      (ce),
      .num     (num6[l]),
      .den     (den6),
      .neg_in  (neg6[l]),
      .quot    (quot[l]),
      .tag_out (dtag[l])
    );
  end

  // cap, apply sign, add principal point, saturate
  function automatic logic [PIX_W:0] finish(input logic [Q_W-1:0] q,
                                            input div_tag_t t,
                                            input logic [CP_W-1:0] c);
    logic [Q_W-1:0]          qc;
    logic signed [Q_W+1:0]   s;
    logic signed [Q_W+1:0]   sum;
    logic                    hi, lo;
    qc  = (t.ovf || q > QUOT_CAP) ? QUOT_CAP : q;
    s   = t.neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    sum = s + $signed((Q_W+2)'(c));
    hi  = sum > $signed((Q_W+2)'(21'h0FFFFF));
    lo  = sum < -$signed((Q_W+2)'(21'h100000));
    if (hi)      finish = {1'b1, 1'b0, {(PIX_W-1){1'b1}}};
    else if (lo) finish = {1'b1, 1'b1, {(PIX_W-1){1'b0}}};
    else         finish = {1'b0, sum[PIX_W-1:0]};
  endfunction

  logic [PIX_W:0] res_u, res_v;
  assign res_u = finish(quot[0], dtag[0], princ[12 +: CP_W]);
  assign res_v = finish(quot[1], dtag[1], princ[F_W+12 +: CP_W]);

  logic [PIX_W-1:0] out_u, out_v;
  logic             out_behind, out_clip, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= ctl[NCTL].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_last   <= ctl[NCTL].last;
      out_behind <= ctl[NCTL].behind;
      // behind the camera: pixels forced to zero, no clip
      out_u      <= ctl[NCTL].behind ? '0 : res_u[PIX_W-1:0];
      out_v      <= ctl[NCTL].behind ? '0 : res_v[PIX_W-1:0];
      out_clip   <= !ctl[NCTL].behind && (res_u[PIX_W] || res_v[PIX_W]);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_v, out_u};
  assign m_axis_tuser  = {out_clip, out_behind};
  assign m_axis_tlast  = out_last;

endmodule

/* rtl/rpp_chk.sv */
// port-level checks for radar_point_to_pixel_projection
// depends on rpp_pkg; bound to the top level below
module rpp_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [47:0]                   m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);
  import rpp_pkg::*;

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");

  // targets behind the camera give zero pixels and no clip
  a_behind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[2*PIX_W-1:0] == '0
                                         && !m_axis_tuser[1])
    else $error("behind item has pixels or clip");

  // input side never blocks while the output side moves
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output free");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("item after reset");

endmodule

bind radar_point_to_pixel_projection rpp_chk u_rpp_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* bench/radar_point_to_pixel_projection_test.sv */
// self-checking bench for the radar point projector: directed table, then random phases
// depends on rpp_pkg and radar_point_to_pixel_projection; expected pixels come from a local predictor
module radar_point_to_pixel_projection_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rpp_pkg::*;

  localparam int  N_RANDOM  = 1650;
  localparam int  QUIET_GAP = 60;      // longer than the pipeline latency
  localparam longint PX_HI  = 1048575;
  localparam longint PX_LO  = -1048576;
  localparam logic [127:0] Q_LIMIT = 128'h100_0000_0000;

  typedef struct {
    logic signed [20:0] u;
    logic signed [20:0] v;
    bit behind;
    bit clip;
    bit last;
  } pixel_t;

  // one directed row: config setting, target, and optionally a typed expectation
  typedef struct {
    int      setting;
    shortint x;
    shortint y;
    bit      last;
    bit      typed;
    pixel_t  want;
  } target_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  radar_point_to_pixel_projection dut (.*);

  // shadow of the register file, index order of cfg_reg_e
  logic [63:0] regs [8];
  pixel_t pending_pixels [$];
  int     mismatches = 0;
  int     targets_sent = 0;
  int     pixels_seen = 0;
  int     behind_seen = 0;
  int     clipped_seen = 0;
  bit     idling = 1'b1;
  int     stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic longint coef_at(input logic [63:0] row, input int k);
    coef_at = longint'($signed(row[16*k +: 16]));
  endfunction

  // one camera-axis pixel: trunc(f*num/(zc*2^12)), capped, plus floor(c/2^12), saturated
  function automatic longint axis_pixel(input longint num, input logic [31:0] f,
                                        input longint zc, input logic [31:0] c,
                                        inout bit clip);
    logic [127:0] mag, quot;
    longint r;
    mag  = 128'(num < 0 ? -num : num);
    quot = (mag * 128'(f)) / (128'(zc) << 12);
    if (quot > Q_LIMIT) quot = Q_LIMIT;
    r = num < 0 ? -longint'(quot[63:0]) : longint'(quot[63:0]);
    r += longint'(c >> 12);
    if (r > PX_HI) begin
      r = PX_HI;
      clip = 1'b1;
    end
    if (r < PX_LO) begin
      r = PX_LO;
      clip = 1'b1;
    end
    axis_pixel = r;
  endfunction

  function automatic pixel_t project_target(input shortint x, input shortint y, input bit last);
    longint w [3];
    longint cam [3];
    pixel_t p;
    bit clip;
    clip = 1'b0;
    // ground plane: z = 0, so column 2 of the first matrix drops out
    for (int i = 0; i < 3; i++)
      w[i] = coef_at(regs[i], 0) * x + coef_at(regs[i], 1) * y + coef_at(regs[i], 3) * 256;
    for (int i = 0; i < 3; i++)
      cam[i] = coef_at(regs[3+i], 0) * w[0] + coef_at(regs[3+i], 1) * w[1]
             + coef_at(regs[3+i], 2) * w[2] + coef_at(regs[3+i], 3) * 1048576;
    p.behind = cam[2] <= 0;
    p.u = '0;
    p.v = '0;
    if (!p.behind) begin
      p.u = 21'(axis_pixel(cam[0], regs[REG_FOCAL][31:0], cam[2], regs[REG_PRINC][31:0], clip));
      p.v = 21'(axis_pixel(cam[1], regs[REG_FOCAL][63:32], cam[2], regs[REG_PRINC][63:32],
                           clip));
    end
    p.clip = clip;
    p.last = last;
    project_target = p;
  endfunction

  // ---------------------------------------------------------------- config

  function automatic logic [63:0] row_of(input int c0, input int c1, input int c2, input int c3);
    row_of = {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
  endfunction

  function automatic int near(input int center, input int spread);
    near = center + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // all eight registers, back to back, while the block is idle
  task automatic load_matrices(input logic [63:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      regs[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  // settings: 1 nominal pose, 2 all-max, 3 all-min, 4 jittered pose, 5 raw random bits
  task automatic apply_setting(input int setting);
    logic [63:0] v [8];
    case (setting)
      1: begin
        // world = radar, camera depth = world y, so y <= 0 lands behind
        v[REG_RW_ROW0] = row_of(4096, 0, 0, 0);
        v[REG_RW_ROW1] = row_of(0, 4096, 0, 0);
        v[REG_RW_ROW2] = '0;
        v[REG_WC_ROW0] = row_of(4096, 0, 0, 0);
        v[REG_WC_ROW1] = row_of(0, 0, -4096, 2048);
        v[REG_WC_ROW2] = row_of(0, 4096, 0, 0);
        v[REG_FOCAL]   = {32'd168215946, 32'd167936212};   // about 2566.8 / 2562.5
        v[REG_PRINC]   = {32'd46465024, 32'd85084313};     // 709 / about 1298.3
      end
      2: begin
        for (int i = 0; i < 6; i++) v[i] = {4{16'h7FFF}};
        v[REG_FOCAL] = '1;
        v[REG_PRINC] = '1;
      end
      3: begin
        for (int i = 0; i < 6; i++) v[i] = {4{16'h8000}};
        v[REG_FOCAL] = '0;
        v[REG_PRINC] = '0;
      end
      4: begin
        v[REG_RW_ROW0] = row_of(near(4096, 800), near(0, 800), near(0, 30000), near(0, 4096));
        v[REG_RW_ROW1] = row_of(near(0, 800), near(4096, 800), near(0, 30000), near(0, 4096));
        v[REG_RW_ROW2] = row_of(near(0, 200), near(0, 200), near(0, 30000), near(0, 1000));
        v[REG_WC_ROW0] = row_of(near(4096, 400), near(0, 400), near(0, 400), near(0, 2000));
        v[REG_WC_ROW1] = row_of(near(0, 400), near(0, 400), near(-4096, 400), near(0, 6000));
        v[REG_WC_ROW2] = row_of(near(0, 400), near(4096, 400), near(0, 400), near(0, 2000));
        v[REG_FOCAL]   = {32'(near(2566, 400)) << 16 | 32'($urandom_range(0, 65535)),
                          32'(near(2562, 400)) << 16 | 32'($urandom_range(0, 65535))};
        v[REG_PRINC]   = {32'(near(709, 300)) << 16 | 32'($urandom_range(0, 65535)),
                          32'(near(1298, 300)) << 16 | 32'($urandom_range(0, 65535))};
      end
      default: begin
        for (int i = 0; i < 8; i++) v[i] = {$urandom, $urandom};
      end
    endcase
    load_matrices(v);
  endtask

  // let every pending pixel drain, then leave room for the pipeline tail
  task automatic drain_pipeline();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (QUIET_GAP) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- target side

  task automatic send_target(input shortint x, input shortint y, input bit last,
                             input bit typed, input pixel_t want);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    pending_pixels.push_back(typed ? want : project_target(x, y, last));
    targets_sent++;
  endtask

  // ---------------------------------------------------------------- pixel side

  task automatic check_pixel();
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      report("pixel with nothing pending, u", longint'($signed(m_axis_tdata[20:0])), 0);
      return;
    end
    want = pending_pixels.pop_front();
    pixels_seen++;
    behind_seen  += want.behind;
    clipped_seen += want.clip;
    if (m_axis_tdata[20:0] !== want.u)
      report("pixel_u", longint'($signed(m_axis_tdata[20:0])), longint'(want.u));
    if (m_axis_tdata[41:21] !== want.v)
      report("pixel_v", longint'($signed(m_axis_tdata[41:21])), longint'(want.v));
    if (m_axis_tuser[0] !== want.behind) report("behind_camera", m_axis_tuser[0], want.behind);
    if (m_axis_tuser[1] !== want.clip) report("clipped", m_axis_tuser[1], want.clip);
    if (m_axis_tlast !== want.last) report("last_out", m_axis_tlast, want.last);
  endtask

  // random back-pressure in bursts; none once idling is switched off
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_pixel();
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    target_row_t plan [$];
    pixel_t none, zero_behind;
    int setting;
    shortint rx, ry;
    none = '{default: 0};
    zero_behind = '{u: 0, v: 0, behind: 1, clip: 0, last: 0};
    // registers out of reset are all zero: depth is zero, every target is behind
    plan.push_back('{0, 16'sh0000, 16'sh0000, 1'b0, 1'b1, zero_behind});
    plan.push_back('{0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1, zero_behind});
    plan.push_back('{0, -16'sh8000, -16'sh8000, 1'b1, 1'b1,
                     '{u: 0, v: 0, behind: 1, clip: 0, last: 1}});
    // nominal pose: y = 0 is zero depth, y < 0 negative depth
    plan.push_back('{1, 16'sh0100, 16'sh0000, 1'b0, 1'b1, zero_behind});
    plan.push_back('{1, 16'sh0000, -16'sh0100, 1'b1, 1'b1,
                     '{u: 0, v: 0, behind: 1, clip: 0, last: 1}});
    plan.push_back('{1, 16'sh0000, 16'sh0A00, 1'b0, 1'b0, none});
    plan.push_back('{1, 16'sh0200, 16'sh1400, 1'b0, 1'b0, none});
    plan.push_back('{1, -16'sh0300, 16'sh3200, 1'b1, 1'b0, none});
    // smallest positive depth with a wide offset: the pixel saturates
    plan.push_back('{1, 16'sh7FFF, 16'sh0001, 1'b0, 1'b0, none});
    plan.push_back('{1, -16'sh8000, 16'sh0001, 1'b0, 1'b0, none});
    plan.push_back('{1, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, none});
    plan.push_back('{1, -16'sh8000, 16'sh7FFF, 1'b1, 1'b0, none});
    plan.push_back('{1, 16'sh5555, 16'sh2AAA, 1'b0, 1'b0, none});
    // extreme register contents
    plan.push_back('{2, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, none});
    plan.push_back('{2, -16'sh8000, 16'sh7FFF, 1'b0, 1'b0, none});
    plan.push_back('{2, 16'sh0001, -16'sh0001, 1'b1, 1'b0, none});
    plan.push_back('{2, 16'sh0000, 16'sh0000, 1'b0, 1'b0, none});
    plan.push_back('{3, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, none});
    plan.push_back('{3, -16'sh8000, -16'sh8000, 1'b0, 1'b0, none});
    plan.push_back('{3, 16'sh0000, -16'sh0001, 1'b1, 1'b0, none});

    for (int i = 0; i < 8; i++) regs[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    setting = 0;
    foreach (plan[i]) begin
      if (plan[i].setting != setting) begin
        s_axis_tvalid <= 1'b0;
        drain_pipeline();
        setting = plan[i].setting;
        apply_setting(setting);
      end
      send_target(plan[i].x, plan[i].y, plan[i].last, plan[i].typed, plan[i].want);
    end

    // random phases: mostly plausible poses with targets in front, some raw bit soup
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) begin
        s_axis_tvalid <= 1'b0;
        drain_pipeline();
        case ((n / 200) % 4)
          0, 2: apply_setting(4);
          1: apply_setting(5);
          default: apply_setting(1 + $urandom_range(0, 4));
        endcase
      end
      if (n >= N_RANDOM - 200) idling = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
        rx = shortint'(near(0, 20000));
        ry = shortint'($urandom_range(1, 20000));
      end else begin
        rx = shortint'($urandom);
        ry = shortint'($urandom);
      end
      send_target(rx, ry, $urandom_range(0, 7) == 0, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;
    drain_pipeline();

    $display("projected %0d targets (%0d pixels checked, %0d behind camera, %0d clipped)",
             targets_sent, pixels_seen, behind_seen, clipped_seen);
    $display("poses: reset, nominal, all-max, all-min, jittered and raw random registers");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
